// ===== rtl/riff_wave_header_parser_top_macros.svh =====
// Assertion helpers used by the RTL; clock clk, reset arst_n in scope.
`ifndef RIFF_WAVE_HEADER_PARSER_TOP_MACROS_SVH
`define RIFF_WAVE_HEADER_PARSER_TOP_MACROS_SVH

// Same-cycle implication.
`define RWHP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rwhp: same-cycle check failed");

// Next-cycle implication.
`define RWHP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rwhp: next-cycle check failed");

`endif

// ===== rtl/rwhp_pkg.sv =====
package rwhp_pkg;

	// result kinds (m_tuser)
	localparam logic [1:0] KIND_FORMAT   = 2'd0;
	localparam logic [1:0] KIND_DATA     = 2'd1;
	localparam logic [1:0] KIND_NOT_WAVE = 2'd2;
	localparam logic [1:0] KIND_UNUSED   = 2'd3;

	// chunk ids, little-endian as they arrive on the byte stream
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam int unsigned RES_W = 160;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} rwhp_item_t;

	// result payload, last field in the lowest bits
	typedef struct packed {
		logic [31:0] data_size;
		logic [15:0] bits_per_sample;
		logic [15:0] block_align;
		logic [31:0] byte_rate;
		logic [31:0] sample_rate;
		logic [15:0] channels;
		logic [15:0] format_tag;
	} rwhp_result_t;

endpackage

// ===== rtl/rwhp_in_reg.sv =====
module rwhp_in_reg
	import rwhp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] first_byte
	input  logic       take,
	output logic       item_valid,
	output rwhp_item_t item
);

	logic       valid_s1;
	rwhp_item_t item_s1;

	assign s_tready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte  <= s_tdata;
			item_s1.first_byte <= s_tuser;
		end
	end

endmodule

// ===== rtl/rwhp_parser.sv =====
`include "riff_wave_header_parser_top_macros.svh"

module rwhp_parser
	import rwhp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  rwhp_item_t         item,
	output logic               take,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [RES_W-1:0]   m_tdata,
	output logic [1:0]         m_tuser
);

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_RIFF_ID   = 4'd1;
	localparam logic [3:0] PH_RIFF_SIZE = 4'd2;
	localparam logic [3:0] PH_WAVE_ID   = 4'd3;
	localparam logic [3:0] PH_F_ID      = 4'd4;
	localparam logic [3:0] PH_F_SIZE    = 4'd5;
	localparam logic [3:0] PH_F_SKIP    = 4'd6;
	localparam logic [3:0] PH_FMT_BODY  = 4'd7;
	localparam logic [3:0] PH_D_ID      = 4'd8;
	localparam logic [3:0] PH_D_SIZE    = 4'd9;
	localparam logic [3:0] PH_D_SKIP    = 4'd10;

	logic [3:0]  phase_q;
	logic [4:0]  byte_index_q;
	logic [31:0] tag_q, size_q, skip_q, rem_q;
	logic [63:0] fields_q, rates_q;

	logic [3:0]  ph, ph_n;
	logic [4:0]  bi, bi_n;
	logic [31:0] tag, tag_n, size, size_n, skip, skip_n, rem, rem_n;
	logic [63:0] fields, fields_n, rates, rates_n;
	logic [31:0] tag_sh, size_sh;
	logic        word_done;
	logic        fire;
	logic [1:0]  kind;
	logic [31:0] dsize;

	logic         m_valid_q;
	logic [1:0]   kind_q;
	rwhp_result_t res_q;
	rwhp_result_t res;

	assign take = item_valid && (!m_valid_q || m_tready);

	// a first byte restarts from cleared state
	always_comb begin
		if (item.first_byte) begin
			ph = PH_RIFF_ID; bi = '0; tag = '0; size = '0; skip = '0; rem = '0;
			fields = '0; rates = '0;
		end else begin
			ph = phase_q; bi = byte_index_q; tag = tag_q; size = size_q; skip = skip_q;
			rem = rem_q; fields = fields_q; rates = rates_q;
		end
	end

	assign tag_sh    = {item.data_byte, tag[31:8]};
	assign size_sh   = {item.data_byte, size[31:8]};
	assign word_done = (bi[1:0] == 2'd3);

	always_comb begin
		ph_n = ph; bi_n = bi; tag_n = tag; size_n = size; skip_n = skip; rem_n = rem;
		fields_n = fields; rates_n = rates;
		fire = 1'b0; kind = KIND_FORMAT; dsize = '0;
		unique case (ph)
			PH_RIFF_ID, PH_WAVE_ID: begin
				tag_n = tag_sh;
				bi_n  = {3'b000, bi[1:0] + 2'd1};
				if (word_done) begin
					if (tag_sh != ((ph == PH_RIFF_ID) ? TAG_RIFF : TAG_WAVE)) begin
						ph_n = PH_IDLE;
						fire = 1'b1;
						kind = KIND_NOT_WAVE;
					end else begin
						ph_n = (ph == PH_RIFF_ID) ? PH_RIFF_SIZE : PH_F_ID;
					end
				end
			end
			PH_RIFF_SIZE: begin
				size_n = size_sh;
				bi_n   = {3'b000, bi[1:0] + 2'd1};
				if (word_done) ph_n = PH_WAVE_ID;
			end
			PH_F_ID, PH_D_ID: begin
				tag_n = tag_sh;
				bi_n  = {3'b000, bi[1:0] + 2'd1};
				if (word_done) ph_n = (ph == PH_F_ID) ? PH_F_SIZE : PH_D_SIZE;
			end
			PH_F_SIZE: begin
				size_n = size_sh;
				bi_n   = {3'b000, bi[1:0] + 2'd1};
				if (word_done) begin
					if (tag == TAG_FMT) begin
						rem_n = size_sh;
						bi_n  = '0;
						if (size_sh == '0) begin
							ph_n = PH_D_ID;
							fire = 1'b1;
						end else begin
							ph_n = PH_FMT_BODY;
						end
					end else begin
						skip_n = size_sh;
						ph_n   = (size_sh == '0) ? PH_F_ID : PH_F_SKIP;
					end
				end
			end
			PH_D_SIZE: begin
				size_n = size_sh;
				bi_n   = {3'b000, bi[1:0] + 2'd1};
				if (word_done) begin
					if (tag == TAG_DATA) begin
						ph_n  = PH_IDLE;
						fire  = 1'b1;
						kind  = KIND_DATA;
						dsize = size_sh;
					end else begin
						skip_n = size_sh;
						ph_n   = (size_sh == '0) ? PH_D_ID : PH_D_SKIP;
					end
				end
			end
			PH_F_SKIP, PH_D_SKIP: begin
				skip_n = skip - 32'd1;
				if (skip == 32'd1) ph_n = (ph == PH_F_SKIP) ? PH_F_ID : PH_D_ID;
			end
			PH_FMT_BODY: begin
				// standard block: tag, channels | rates | align, bits
				if (!bi[4]) begin
					for (int j = 0; j < 8; j++) begin
						if ((j < 4 && bi[3:0] == 4'(j)) || (j >= 4 && bi[3:0] == 4'(j + 8)))
							fields_n[8*j +: 8] = item.data_byte;
						if (bi[3:0] == 4'(j + 4))
							rates_n[8*j +: 8] = item.data_byte;
					end
					bi_n = bi + 5'd1;
					if (bi[3:0] == 4'd15) fire = 1'b1;
				end
				rem_n = rem - 32'd1;
				if (rem == 32'd1) begin
					if (!bi_n[4]) fire = 1'b1;
					bi_n = '0;
					ph_n = PH_D_ID;
				end
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase
	end

	always_comb begin
		res.format_tag      = fields_n[15:0];
		res.channels        = fields_n[31:16];
		res.sample_rate     = rates_n[31:0];
		res.byte_rate       = rates_n[63:32];
		res.block_align     = fields_n[47:32];
		res.bits_per_sample = fields_n[63:48];
		res.data_size       = dsize;
		if (kind == KIND_NOT_WAVE) res = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			byte_index_q <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (take) begin
				phase_q      <= ph_n;
				byte_index_q <= bi_n;
				m_valid_q    <= fire;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0; size_q <= '0; skip_q <= '0; rem_q <= '0;
			fields_q <= '0; rates_q <= '0;
		end else if (take) begin
			tag_q <= tag_n; size_q <= size_n; skip_q <= skip_n; rem_q <= rem_n;
			fields_q <= fields_n; rates_q <= rates_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && fire) begin
			kind_q <= kind;
			res_q  <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = res_q;

	`RWHP_ASSERT_NOW(a_kind_range, m_valid_q, kind_q != KIND_UNUSED)
	`RWHP_ASSERT_NOW(a_not_wave_clean, m_valid_q && kind_q == KIND_NOT_WAVE, res_q == '0)
	`RWHP_ASSERT_NEXT(a_final_to_idle, take && fire && kind != KIND_FORMAT, phase_q == PH_IDLE)
	`RWHP_ASSERT_NOW(a_index_bound, 1'b1, byte_index_q <= 5'd16)
	`RWHP_ASSERT_NOW(a_body_left, phase_q == PH_FMT_BODY, rem_q != '0)

endmodule

// ===== rtl/riff_wave_header_parser_top.sv =====
// RIFF/WAVE header parser. Feed a WAV file one byte per transaction on the
// slave stream, with s_tuser high on the first byte of each file (that byte
// restarts the parser from any state). The block checks the "RIFF" and "WAVE"
// magics, walks chunks to "fmt ", unpacks its 16-byte standard block and
// then walks on to "data". It gives at most one result per byte: kind 0 once
// the format block is complete (or the fmt chunk ends early, missing fields
// zero), kind 1 on the last size byte of the data chunk carrying its size,
// kind 2 on a bad magic with all fields zero. Chunk sizes are unsigned
// 32-bit and odd-sized chunks get no pad byte. After kind 1 or kind 2 bytes
// are ignored until the next first byte. Throughput is one byte per clock
// while results are taken: each byte passes an input register and the parse
// logic into the result register, from which its result is offered on
// m_tvalid. A result held on m_tready stalls the parse stage; the input
// register then takes at most one more byte and s_tready stays low until the
// result leaves.
module riff_wave_header_parser_top
	import rwhp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] data_byte
	input  logic             s_tuser,   // [0] first_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	// [15:0] format_tag, [31:16] channels, [63:32] sample_rate,
	// [95:64] byte_rate, [111:96] block_align, [127:112] bits_per_sample,
	// [159:128] data_size
	output logic [RES_W-1:0] m_tdata,
	output logic [1:0]       m_tuser    // [1:0] kind
);

	logic       item_valid;
	logic       take;
	rwhp_item_t item;

	// input register: one byte held while the parse stage is stalled
	rwhp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	// parse state, field capture and result register
	rwhp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.take       (take),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== bench/riff_wave_header_parser_checker.sv =====
module riff_wave_header_parser_checker
	import rwhp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] data_byte
	input  logic             s_tuser,   // [0] first_byte
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [RES_W-1:0] m_tdata,   // result fields, format_tag lowest
	input  logic [1:0]       m_tuser,   // [1:0] kind
	output int unsigned      fail_count,
	output int unsigned      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		P_IDLE, P_RIFF_ID, P_RIFF_SIZE, P_WAVE_ID,
		P_FMT_ID, P_FMT_SIZE, P_FMT_SKIP, P_FMT_BODY,
		P_DATA_ID, P_DATA_SIZE, P_DATA_SKIP
	} parse_phase_t;

	typedef struct packed {
		logic [1:0]   kind;
		rwhp_result_t fields;
	} header_report_t;

	parse_phase_t   phase_q = P_IDLE;
	logic [4:0]     pos = '0;
	logic [31:0]    tag_word = '0;
	logic [31:0]    size_word = '0;
	logic [31:0]    skip_left = '0;
	logic [31:0]    fmt_left = '0;
	logic [127:0]   fmt_block = '0;   // same layout as the low 128 bits of m_tdata
	header_report_t reports_q[$];
	int unsigned    fails = 0;
	int unsigned    waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	function automatic void clear_parser();
		phase_q   = P_IDLE;
		pos       = '0;
		tag_word  = '0;
		size_word = '0;
		skip_left = '0;
		fmt_left  = '0;
		fmt_block = '0;
	endfunction

	// little-endian word assembly; true once the fourth byte is in
	function automatic bit shift_word(input logic [7:0] b, input bit to_size);
		logic [1:0]  k;
		logic [31:0] w;
		k = pos[1:0];
		w = to_size ? size_word : tag_word;
		if (k == 2'd0)
			w = '0;
		w = w | (32'(b) << (8 * k));
		if (to_size)
			size_word = w;
		else
			tag_word = w;
		k = k + 2'd1;
		pos = {3'b000, k};
		return k == 2'd0;
	endfunction

	function automatic bit parse_header_byte(input logic [7:0] b, input logic first,
			output header_report_t rep);
		bit         fire;
		logic [1:0] kind;
		fire = 1'b0;
		kind = KIND_FORMAT;
		if (first) begin
			clear_parser();
			phase_q = P_RIFF_ID;
		end
		case (phase_q)
			P_RIFF_ID: begin
				if (shift_word(b, 1'b0)) begin
					if (tag_word != TAG_RIFF) begin
						phase_q = P_IDLE;
						fire = 1'b1;
						kind = KIND_NOT_WAVE;
					end else begin
						phase_q = P_RIFF_SIZE;
					end
				end
			end
			P_RIFF_SIZE: begin
				if (shift_word(b, 1'b1))
					phase_q = P_WAVE_ID;
			end
			P_WAVE_ID: begin
				if (shift_word(b, 1'b0)) begin
					if (tag_word != TAG_WAVE) begin
						phase_q = P_IDLE;
						fire = 1'b1;
						kind = KIND_NOT_WAVE;
					end else begin
						phase_q = P_FMT_ID;
					end
				end
			end
			P_FMT_ID: begin
				if (shift_word(b, 1'b0))
					phase_q = P_FMT_SIZE;
			end
			P_FMT_SIZE: begin
				if (shift_word(b, 1'b1)) begin
					if (tag_word == TAG_FMT) begin
						fmt_left = size_word;
						if (fmt_left == 0) begin
							// empty fmt chunk reports on its last size byte
							phase_q = P_DATA_ID;
							fire = 1'b1;
						end else begin
							phase_q = P_FMT_BODY;
						end
					end else begin
						skip_left = size_word;
						if (skip_left == 0)
							phase_q = P_FMT_ID;
						else
							phase_q = P_FMT_SKIP;
					end
				end
			end
			P_FMT_SKIP: begin
				skip_left = skip_left - 1;
				if (skip_left == 0)
					phase_q = P_FMT_ID;
			end
			P_FMT_BODY: begin
				if (pos < 5'd16) begin
					fmt_block[8 * pos +: 8] = b;
					pos = pos + 5'd1;
					if (pos == 5'd16)
						fire = 1'b1;
				end
				fmt_left = fmt_left - 1;
				if (fmt_left == 0) begin
					// a short chunk reports on its last byte
					if (pos < 5'd16)
						fire = 1'b1;
					pos = '0;
					phase_q = P_DATA_ID;
				end
			end
			P_DATA_ID: begin
				if (shift_word(b, 1'b0))
					phase_q = P_DATA_SIZE;
			end
			P_DATA_SIZE: begin
				if (shift_word(b, 1'b1)) begin
					if (tag_word == TAG_DATA) begin
						phase_q = P_IDLE;
						fire = 1'b1;
						kind = KIND_DATA;
					end else begin
						skip_left = size_word;
						if (skip_left == 0)
							phase_q = P_DATA_ID;
						else
							phase_q = P_DATA_SKIP;
					end
				end
			end
			P_DATA_SKIP: begin
				skip_left = skip_left - 1;
				if (skip_left == 0)
					phase_q = P_DATA_ID;
			end
			default: begin
				phase_q = P_IDLE;
			end
		endcase
		rep.kind   = kind;
		rep.fields = '0;
		if (kind != KIND_NOT_WAVE)
			rep.fields = {(kind == KIND_DATA) ? size_word : 32'd0, fmt_block};
		return fire;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		header_report_t rep;
		header_report_t want;
		rwhp_result_t   got;
		if (!arst_n) begin
			clear_parser();
			reports_q.delete();
		end else begin
			// a result leaves only after its byte has passed both DUT registers, so check first
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (reports_q.size() == 0) begin
					$error("unexpected result transaction, kind %0d", m_tuser);
					fails++;
				end else begin
					want = reports_q.pop_front();
					check_field("kind", 32'(want.kind), 32'(m_tuser));
					check_field("format_tag", 32'(want.fields.format_tag),
						32'(got.format_tag));
					check_field("channels", 32'(want.fields.channels), 32'(got.channels));
					check_field("sample_rate", want.fields.sample_rate, got.sample_rate);
					check_field("byte_rate", want.fields.byte_rate, got.byte_rate);
					check_field("block_align", 32'(want.fields.block_align),
						32'(got.block_align));
					check_field("bits_per_sample", 32'(want.fields.bits_per_sample),
						32'(got.bits_per_sample));
					check_field("data_size", want.fields.data_size, got.data_size);
				end
			end
			if (s_tvalid && s_tready) begin
				if (parse_header_byte(s_tdata, s_tuser, rep))
					reports_q.push_back(rep);
			end
		end
		waiting = reports_q.size();
	end

endmodule

// ===== bench/riff_wave_header_parser_top_test.sv =====
module riff_wave_header_parser_top_test
	import rwhp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// long receiver hold-off, enough to back the block up into its input
	localparam int unsigned HOLD_CYCLES    = 300;
	// cycles without any transaction before the run is abandoned
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// settle time after the last result
	localparam int unsigned DRAIN_CYCLES   = 20;
	// bytes of random files per idling phase
	localparam int unsigned PHASE_BYTES    = 260;

	// chunk ids that a real file carries and the parser must skip
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;   // "LIST"
	localparam logic [31:0] TAG_FACT = 32'h7463_6166;   // "fact"

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;   // [7:0] data_byte
	logic             s_tuser = 1'b0; // [0] first_byte
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [RES_W-1:0] m_tdata;        // format_tag lowest ... data_size highest
	logic [1:0]       m_tuser;        // [1:0] kind

	int unsigned fail_count;
	int unsigned pending;

	// idling odds in percent, set per phase by the stimulus process
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	// hold-off requests: stimulus bumps the first, receiver catches up
	int unsigned hold_asks = 0;
	int unsigned hold_served = 0;

	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;
	logic [7:0]  file_bytes[$];   // file under construction

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	riff_wave_header_parser_top DUT (.*);

	riff_wave_header_parser_checker header_check (.*);

	// Receiver: random back-pressure, plus a long hold when asked. The hold is
	// counted here so the sender keeps offering bytes meanwhile.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_asks != hold_served) begin
				hold_served = hold_asks;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: any transaction on either side resets the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// One byte transaction. Optional idle gap first; valid is never dropped
	// and raised in the same step, so back-to-back bytes keep it high.
	task automatic push_byte(input logic [7:0] b, input logic first);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Send the built file, first byte flagged, then some stray bytes that a
	// finished parser has to ignore.
	task automatic send_file(input int unsigned tail);
		foreach (file_bytes[i])
			push_byte(file_bytes[i], i == 0);
		bytes_sent += file_bytes.size();
		repeat (tail)
			push_byte(8'($urandom), 1'b0);
		file_bytes.delete();
	endtask

	// Sender goes quiet until every predicted result has come out.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	function automatic void put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_bytes.push_back(w[8 * i +: 8]);
	endfunction

	function automatic int unsigned chunk_len();
		return ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(9);
	endfunction

	function automatic void put_chunk(input logic [31:0] id, input int unsigned len);
		put_word(id);
		put_word(len);
		repeat (len)
			file_bytes.push_back(8'($urandom));
	endfunction

	// Ids for chunks in front of fmt / data: common ones, the other magic
	// (skipped while not looked for), near misses of the wanted one and random ids.
	function automatic logic [31:0] pick_chunk_id(input bit seeking_data);
		case ($urandom_range(4))
			0: return TAG_LIST;
			1: return TAG_FACT;
			2: return seeking_data ? TAG_FMT : TAG_DATA;
			3: return (seeking_data ? TAG_DATA : TAG_FMT) ^ (32'd1 << $urandom_range(31));
			default: return $urandom;
		endcase
	endfunction

	// Well-formed header: RIFF, WAVE, extras, fmt, extras, data.
	// A negative extra_len gives each extra chunk a random length.
	function automatic void make_wave(input int unsigned fmt_len, input logic [127:0] fmt_blk,
			input logic [31:0] data_len, input int unsigned pre_fmt,
			input int unsigned pre_data, input int extra_len);
		put_word(TAG_RIFF);
		put_word($urandom);
		put_word(TAG_WAVE);
		repeat (pre_fmt)
			put_chunk(pick_chunk_id(1'b0), (extra_len < 0) ? chunk_len() : extra_len);
		put_word(TAG_FMT);
		put_word(fmt_len);
		for (int unsigned p = 0; p < fmt_len; p++) begin
			if (p < 16)
				file_bytes.push_back(fmt_blk[8 * p +: 8]);
			else
				file_bytes.push_back(8'($urandom));
		end
		repeat (pre_data)
			put_chunk(pick_chunk_id(1'b1), (extra_len < 0) ? chunk_len() : extra_len);
		put_word(TAG_DATA);
		put_word(data_len);
	endfunction

	// Mostly well-formed files with random content; the rest is noise, broken
	// magics and files cut short so the next one restarts the parser mid-way.
	task automatic random_wave();
		int unsigned  shape;
		int unsigned  fmt_len;
		int unsigned  cut;
		int unsigned  bits;
		int unsigned  chans;
		int unsigned  rate;
		logic [127:0] blk;
		logic [31:0]  dlen;
		shape = $urandom_range(99);
		if (shape < 4) begin
			repeat ($urandom_range(1, 12))
				file_bytes.push_back(8'($urandom));
			send_file(0);
		end else begin
			case ($urandom_range(9))
				8, 9: fmt_len = $urandom_range(15);
				6, 7: fmt_len = 16 + $urandom_range(1, 8);
				default: fmt_len = 16;
			endcase
			if ($urandom_range(1)) begin
				blk = {$urandom, $urandom, $urandom, $urandom};
			end else begin
				// plausible PCM block
				bits  = 8 * $urandom_range(1, 4);
				chans = $urandom_range(1, 8);
				rate  = $urandom_range(8000, 192000);
				blk = {16'(bits), 16'(chans * bits / 8), 32'(rate * chans * bits / 8),
					32'(rate), 16'(chans), 16'd1};
			end
			case ($urandom_range(3))
				0: dlen = '0;
				1: dlen = '1;
				2: dlen = $urandom_range(4096);
				default: dlen = $urandom;
			endcase
			make_wave(fmt_len, blk, dlen, $urandom_range(2), $urandom_range(2), -1);
			if (shape < 10) begin
				file_bytes[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
			end else if (shape < 16) begin
				file_bytes[$urandom_range(8, 11)] ^= 8'(1 << $urandom_range(7));
			end else if (shape < 28) begin
				cut = $urandom_range(1, file_bytes.size() - 1);
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end
			send_file((shape >= 28) ? $urandom_range(3) : 0);
		end
	endtask

	initial begin
		int unsigned goal;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// wrong RIFF magic, then stray bytes while idle
		put_word(TAG_RIFF ^ 32'h2000_0000);
		send_file(2);
		// good RIFF, largest size, wrong WAVE magic
		put_word(TAG_RIFF);
		put_word('1);
		put_word(TAG_WAVE ^ 32'h0000_0001);
		send_file(0);
		// every format field and the data size at all ones
		make_wave(16, '1, '1, 0, 0, -1);
		send_file(3);
		// empty fmt chunk, zero-sized chunks around it, empty data chunk
		make_wave(0, '0, '0, 1, 1, 0);
		send_file(0);
		// short fmt chunk, odd-sized chunk before data (no pad byte)
		make_wave(7, {$urandom, $urandom, $urandom, $urandom}, $urandom, 0, 1, 3);
		send_file(0);
		// long fmt chunk cut off mid-file: the next first byte restarts
		make_wave(21, '0, 32'd1, 1, 0, 5);
		while (file_bytes.size() > 30)
			void'(file_bytes.pop_back());
		send_file(0);
		make_wave(21, {$urandom, $urandom, $urandom, $urandom}, 32'd1, 0, 0, -1);
		send_file(1);
		drain_results();

		// --- back-pressure: receiver holds off while files keep coming ---
		hold_asks++;
		repeat (3) begin
			make_wave(16, {$urandom, $urandom, $urandom, $urandom}, $urandom, 0, 1, -1);
			send_file(0);
		end
		drain_results();

		// --- random files, one idling pattern per phase ---
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 54;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 54;
				end
				default: begin
					send_idle_pct  = 17;
					recv_stall_pct = 17;
				end
			endcase
			goal = bytes_sent + PHASE_BYTES;
			while (bytes_sent < goal)
				random_wave();
			drain_results();
		end

		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
